@@ rtl/core/tsr_pkg.sv @@
// ----------------------------------------------------------------------------
// tsr_pkg
// Shared types and constants for the timestamped sample ring.
// ----------------------------------------------------------------------------
package tsr_pkg;

    localparam int NUM_BLOCKS_DEF     = 8;
    localparam int BLOCK_CAPACITY_DEF = 256;
    localparam int MAX_READ_DEF       = 64;

    localparam int SAMPLE_W = 16;
    localparam int TIME_W   = 64;
    localparam int LEN_W    = 9;
    localparam int REQ_W    = 7;
    localparam int STAT_W   = 2;

    localparam logic [LEN_W-1:0] LIMIT_RESET = 9'd256;

    // action codes
    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_READ = 1'b1;

    // result status codes
    localparam logic [STAT_W-1:0] STAT_COMMIT = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL   = 2'd1;
    localparam logic [STAT_W-1:0] STAT_DATA   = 2'd2;
    localparam logic [STAT_W-1:0] STAT_EMPTY  = 2'd3;

    typedef struct packed {
        logic                action;
        logic [SAMPLE_W-1:0] in_sample_i;
        logic [SAMPLE_W-1:0] in_sample_q;
        logic [TIME_W-1:0]   block_time;
        logic                end_of_block;
        logic [REQ_W-1:0]    request_count;
    } t_in_item;

    typedef struct packed {
        logic [STAT_W-1:0]   status;
        logic [SAMPLE_W-1:0] out_sample_i;
        logic [SAMPLE_W-1:0] out_sample_q;
        logic [TIME_W-1:0]   chunk_time;
        logic [LEN_W-1:0]    sample_count;
        logic                last_result;
    } t_result;

    // per-block bookkeeping kept in the block table
    typedef struct packed {
        logic [TIME_W-1:0] time_stamp;
        logic [LEN_W-1:0]  len;
    } t_meta;

    typedef struct packed {
        logic push;      // take a pushed sample
        logic rd_start;  // take a read request
        logic rd_meta;   // block table data is valid, size the chunk
        logic rd_issue;  // fetch one sample of the chunk
    } t_ctrl_cmd;

    typedef struct packed {
        logic empty;       // no committed block waits
        logic n_zero;      // chunk holds no samples
        logic issue_last;  // this fetch is the last of the chunk
    } t_ctrl_status;

endpackage

@@ rtl/core/timestamped_sample_ring.sv @@
// Push: one sample per cycle, busy stays low; a commit or full result shows
//   the cycle after the sample that ends the block.
// Read: a block table lookup, then one sample per cycle from the sample RAM;
//   a chunk of no samples gives a single result, and busy drops after the last fetch.
// Empty read: one result the next cycle, busy stays low.
// Synchronous active-low reset clears pointers and fill state and sets the limit to 256.
// ----------------------------------------------------------------------------
// timestamped_sample_ring
// Ring of timestamped I/Q sample blocks with push and chunked read.
// ----------------------------------------------------------------------------
module timestamped_sample_ring
    import tsr_pkg::*;
#(
    parameter int NUM_BLOCKS     = NUM_BLOCKS_DEF,
    parameter int BLOCK_CAPACITY = BLOCK_CAPACITY_DEF,
    parameter int MAX_READ       = MAX_READ_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [LEN_W-1:0] i_cfg_wdata,
    input  logic             start,
    output logic             busy,
    input  t_in_item         i_item,
    output logic             o_result_valid,
    output t_result          o_result
);

    t_ctrl_cmd    ctrl_cmd;
    t_ctrl_status ctrl_status;

    tsr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_action(i_item.action),
        .i_status(ctrl_status),
        .o_cmd   (ctrl_cmd),
        .busy    (busy)
    );

    tsr_datapath #(
        .NUM_BLOCKS    (NUM_BLOCKS),
        .BLOCK_CAPACITY(BLOCK_CAPACITY),
        .MAX_READ      (MAX_READ)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_item        (i_item),
        .i_cmd         (ctrl_cmd),
        .o_status      (ctrl_status),
        .o_result_valid(o_result_valid),
        .o_result      (o_result)
    );

endmodule

@@ rtl/core/tsr_ram.sv @@
// ----------------------------------------------------------------------------
// tsr_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module tsr_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/tsr_ctrl.sv @@
// ----------------------------------------------------------------------------
// tsr_ctrl
// Sequencer: takes items, steps a read through table lookup and sample fetch.
// ----------------------------------------------------------------------------
module tsr_ctrl
    import tsr_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         start,
    input  logic         i_action,
    input  t_ctrl_status i_status,
    output t_ctrl_cmd    o_cmd,
    output logic         busy
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_META   = 2'd1;
    localparam logic [1:0] S_STREAM = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (i_action == ACT_PUSH) begin
                        o_cmd.push = 1'b1;
                    end else begin
                        o_cmd.rd_start = 1'b1;
                        if (!i_status.empty) begin
                            n_state = S_META;
                        end
                    end
                end
            end
            S_META: begin
                o_cmd.rd_meta = 1'b1;
                n_state = i_status.n_zero ? S_IDLE : S_STREAM;
            end
            S_STREAM: begin
                o_cmd.rd_issue = 1'b1;
                if (i_status.issue_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != S_IDLE);

endmodule

@@ rtl/core/tsr_datapath.sv @@
// ----------------------------------------------------------------------------
// tsr_datapath
// Ring pointers, block fill, sample store, block table and result registers.
// ----------------------------------------------------------------------------
module tsr_datapath
    import tsr_pkg::*;
#(
    parameter int NUM_BLOCKS     = NUM_BLOCKS_DEF,
    parameter int BLOCK_CAPACITY = BLOCK_CAPACITY_DEF,
    parameter int MAX_READ       = MAX_READ_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [LEN_W-1:0] i_cfg_wdata,
    input  t_in_item         i_item,
    input  t_ctrl_cmd        i_cmd,
    output t_ctrl_status     o_status,
    output logic             o_result_valid,
    output t_result          o_result
);

    localparam int SLOT_W  = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int OFS_W   = (BLOCK_CAPACITY > 1) ? $clog2(BLOCK_CAPACITY) : 1;
    localparam int SADDR_W = SLOT_W + OFS_W;
    localparam int SDEPTH  = NUM_BLOCKS << OFS_W;
    localparam int META_W  = TIME_W + LEN_W;

    function automatic logic [SLOT_W-1:0] f_next(input logic [SLOT_W-1:0] s);
        return (s == SLOT_W'(NUM_BLOCKS - 1)) ? '0 : s + 1'b1;
    endfunction

    // control state
    logic [LEN_W-1:0]  r_limit;
    logic [SLOT_W-1:0] r_ws;
    logic [SLOT_W-1:0] r_rs;
    logic [OFS_W-1:0]  r_offset;
    logic [LEN_W-1:0]  r_fill;
    logic              r_drop;
    logic              r_res_valid;
    logic              r_strm_valid;
    logic              r_strm_last;

    // payload
    logic [TIME_W-1:0] r_push_time;
    logic [REQ_W-1:0]  r_req;
    logic [REQ_W-1:0]  r_n;
    logic [REQ_W-1:0]  r_k;
    logic [LEN_W-1:0]  r_len;
    logic [TIME_W-1:0] r_time;
    logic              r_drained;
    t_result           r_result;
    t_result           n_result;

    // push side
    logic              push_first;
    logic              push_drop;
    logic              push_store;
    logic [LEN_W-1:0]  eff_limit;
    logic [LEN_W-1:0]  fill_next;
    logic [TIME_W-1:0] push_time;
    logic              commit;

    // read side
    t_meta             meta_q;
    logic [META_W-1:0] meta_rdata;
    logic              rd_drained;
    logic [REQ_W-1:0]  rd_n;
    logic [REQ_W-1:0]  req_clamp;
    logic              fin_do;
    logic [TIME_W-1:0] fin_time;
    logic [LEN_W-1:0]  fin_len;
    logic [REQ_W-1:0]  fin_n;
    logic              fin_drained;

    // memory ports
    logic               meta_we;
    logic [SLOT_W-1:0]  meta_waddr;
    t_meta              meta_wdata;
    logic               smp_we;
    logic [SADDR_W-1:0] smp_waddr;
    logic [SADDR_W-1:0] smp_raddr;
    logic [31:0]        smp_rdata;

    assign eff_limit  = (r_limit == '0) ? LEN_W'(1) : r_limit;
    assign push_first = (r_fill == '0) && !r_drop;
    assign push_drop  = r_drop || (push_first && (f_next(r_ws) == r_rs));
    assign push_store = !push_drop && (r_fill < eff_limit)
                        && (32'(r_fill) < 32'(BLOCK_CAPACITY));
    assign fill_next  = r_fill + LEN_W'(push_store);
    assign push_time  = push_first ? i_item.block_time : r_push_time;
    assign commit     = i_cmd.push && i_item.end_of_block && !push_drop;

    assign req_clamp = (32'(i_item.request_count) > 32'(MAX_READ)) ?
                       REQ_W'(MAX_READ) : i_item.request_count;

    assign meta_q     = t_meta'(meta_rdata);
    assign rd_drained = (meta_q.len <= LEN_W'(r_req));
    assign rd_n       = rd_drained ? REQ_W'(meta_q.len) : r_req;

    assign o_status.empty      = (r_ws == r_rs);
    assign o_status.n_zero     = (rd_n == '0);
    assign o_status.issue_last = ((r_k + REQ_W'(1)) == r_n);

    // finish a read: either a zero-sample chunk in lookup, or the last fetch
    assign fin_do      = (i_cmd.rd_meta && o_status.n_zero)
                         || (i_cmd.rd_issue && o_status.issue_last);
    assign fin_time    = i_cmd.rd_meta ? meta_q.time_stamp : r_time;
    assign fin_len     = i_cmd.rd_meta ? meta_q.len : r_len;
    assign fin_n       = i_cmd.rd_meta ? rd_n : r_n;
    assign fin_drained = i_cmd.rd_meta ? rd_drained : r_drained;

    always_comb begin
        meta_we    = commit || fin_do;
        meta_waddr = i_cmd.push ? r_ws : r_rs;
        if (i_cmd.push) begin
            meta_wdata.time_stamp = push_time;
            meta_wdata.len        = fill_next;
        end else begin
            meta_wdata.time_stamp = fin_time + TIME_W'(fin_n);
            meta_wdata.len        = fin_drained ? '0 : fin_len - LEN_W'(fin_n);
        end
    end

    assign smp_we    = i_cmd.push && push_store;
    assign smp_waddr = {r_ws, OFS_W'(r_fill)};
    assign smp_raddr = {r_rs, r_offset + OFS_W'(r_k)};

    tsr_ram #(
        .WIDTH (META_W),
        .DEPTH (NUM_BLOCKS),
        .ADDR_W(SLOT_W)
    ) u_meta_ram (
        .i_clk  (i_clk),
        .i_we   (meta_we),
        .i_waddr(meta_waddr),
        .i_wdata(meta_wdata),
        .i_re   (1'b1),
        .i_raddr(r_rs),
        .o_rdata(meta_rdata)
    );

    tsr_ram #(
        .WIDTH (32),
        .DEPTH (SDEPTH),
        .ADDR_W(SADDR_W)
    ) u_sample_ram (
        .i_clk  (i_clk),
        .i_we   (smp_we),
        .i_waddr(smp_waddr),
        .i_wdata({i_item.in_sample_i, i_item.in_sample_q}),
        .i_re   (i_cmd.rd_issue),
        .i_raddr(smp_raddr),
        .o_rdata(smp_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit      <= LIMIT_RESET;
            r_ws         <= '0;
            r_rs         <= '0;
            r_offset     <= '0;
            r_fill       <= '0;
            r_drop       <= 1'b0;
            r_res_valid  <= 1'b0;
            r_strm_valid <= 1'b0;
            r_strm_last  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            r_res_valid  <= (i_cmd.push && i_item.end_of_block)
                            || (i_cmd.rd_start && o_status.empty)
                            || (i_cmd.rd_meta && o_status.n_zero);
            r_strm_valid <= i_cmd.rd_issue;
            r_strm_last  <= i_cmd.rd_issue && o_status.issue_last;
            if (i_cmd.push) begin
                if (i_item.end_of_block) begin
                    r_fill <= '0;
                    r_drop <= 1'b0;
                    if (!push_drop) begin
                        r_ws <= f_next(r_ws);
                    end
                end else begin
                    r_fill <= fill_next;
                    r_drop <= push_drop;
                end
            end
            if (fin_do) begin
                if (fin_drained) begin
                    r_offset <= '0;
                    r_rs     <= f_next(r_rs);
                end else begin
                    r_offset <= r_offset + OFS_W'(fin_n);
                end
            end
        end
    end

    always_comb begin
        n_result             = '0;
        n_result.last_result = 1'b1;
        if (i_cmd.push) begin
            if (push_drop) begin
                n_result.status = STAT_FULL;
            end else begin
                n_result.status       = STAT_COMMIT;
                n_result.chunk_time   = push_time;
                n_result.sample_count = fill_next;
            end
        end else if (i_cmd.rd_start) begin
            n_result.status = STAT_EMPTY;
        end else begin
            // zero-sample chunk
            n_result.status     = STAT_DATA;
            n_result.chunk_time = meta_q.time_stamp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push && push_first) begin
            r_push_time <= i_item.block_time;
        end
        if (i_cmd.rd_start) begin
            r_req <= req_clamp;
        end
        if (i_cmd.rd_meta) begin
            r_n       <= rd_n;
            r_len     <= meta_q.len;
            r_time    <= meta_q.time_stamp;
            r_drained <= rd_drained;
            r_k       <= '0;
        end else if (i_cmd.rd_issue) begin
            r_k <= r_k + REQ_W'(1);
        end
        r_result <= n_result;
    end

    always_comb begin
        if (r_strm_valid) begin
            o_result.status       = STAT_DATA;
            o_result.out_sample_i = smp_rdata[31:16];
            o_result.out_sample_q = smp_rdata[15:0];
            o_result.chunk_time   = r_time;
            o_result.sample_count = LEN_W'(r_n);
            o_result.last_result  = r_strm_last;
        end else begin
            o_result = r_result;
        end
    end

    assign o_result_valid = r_res_valid || r_strm_valid;

endmodule

@@ rtl/core/tsr_checker.sv @@
// ----------------------------------------------------------------------------
// tsr_checker
// Port-level checks on item acceptance and result timing.
// ----------------------------------------------------------------------------
module tsr_checker
    import tsr_pkg::*;
(
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     start,
    input logic     busy,
    input t_in_item i_item,
    input logic     o_result_valid,
    input t_result  o_result
);

    logic accept;
    assign accept = start && !busy;

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !busy && !o_result_valid)
        else $error("block not idle after reset");

    a_push_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (i_item.action == ACT_PUSH) && !i_item.end_of_block
        |=> !o_result_valid)
        else $error("result after push without end of block");

    a_push_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (i_item.action == ACT_PUSH) && i_item.end_of_block
        |=> o_result_valid && o_result.last_result
            && (o_result.status == STAT_COMMIT || o_result.status == STAT_FULL))
        else $error("missing commit result after end of block");

    a_read_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (i_item.action == ACT_READ)
        |=> busy || (o_result_valid && o_result.status == STAT_EMPTY))
        else $error("read neither started nor reported empty");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && (o_result.status == STAT_FULL)
        |-> (o_result.sample_count == '0))
        else $error("dropped block reports samples");

endmodule

bind timestamped_sample_ring tsr_checker u_tsr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .i_item        (i_item),
    .o_result_valid(o_result_valid),
    .o_result      (o_result)
);

@@ verif/timestamped_sample_ring_tb.sv @@
// ----------------------------------------------------------------------------
// timestamped_sample_ring_tb
// Self-checking bench for the timestamped sample ring. A table of directed
// transactions covers the empty, full, clamp and zero-length cases, then
// random block pushes and chunked reads run under several length limits.
// Every result is compared field by field against an in-bench ring model or a typed row.
// ----------------------------------------------------------------------------
module timestamped_sample_ring_tb;
    import tsr_pkg::*;

    localparam int RING_BLOCKS  = NUM_BLOCKS_DEF;
    localparam int BLOCK_DEPTH  = BLOCK_CAPACITY_DEF;
    localparam int READ_CAP     = MAX_READ_DEF;
    localparam int QUIET_LIMIT  = 500;
    localparam int REPORT_LIMIT = 10;

    logic             i_clk;
    logic             i_rst_n     = 1'b0;
    logic             i_cfg_we    = 1'b0;
    logic [LEN_W-1:0] i_cfg_wdata = '0;
    logic             start       = 1'b0;
    logic             busy;
    t_in_item         i_item      = '0;
    logic             o_result_valid;
    t_result          o_result;

    typedef struct {
        t_in_item item;
        bit       typed;
        t_result  want;
    } t_plan_row;

    t_plan_row directed_plan[$];

    // ring model state
    logic [31:0]       ring_mem  [RING_BLOCKS*BLOCK_DEPTH];
    logic [TIME_W-1:0] blk_stamp [RING_BLOCKS];
    int unsigned       blk_len   [RING_BLOCKS] = '{default: 0};
    int unsigned       wr_blk    = 0;
    int unsigned       rd_blk    = 0;
    int unsigned       rd_pos    = 0;
    int unsigned       fill_cnt  = 0;
    bit                dropping  = 1'b0;
    logic [LEN_W-1:0]  length_limit = LIMIT_RESET;

    t_result awaited_results[$];
    int      error_count  = 0;
    int      quiet_cycles = 0;

    timestamped_sample_ring dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .start          (start),
        .busy           (busy),
        .i_item         (i_item),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic int unsigned next_blk(int unsigned s);
        return (s + 1 == RING_BLOCKS) ? 0 : s + 1;
    endfunction

    function automatic logic [SAMPLE_W-1:0] rand_sample();
        return SAMPLE_W'($urandom_range(0, 65535));
    endfunction

    function automatic t_in_item push_item(logic [SAMPLE_W-1:0] si, logic [SAMPLE_W-1:0] sq,
                                           logic [TIME_W-1:0] ts, logic eob);
        t_in_item it;
        it.action        = ACT_PUSH;
        it.in_sample_i   = si;
        it.in_sample_q   = sq;
        it.block_time    = ts;
        it.end_of_block  = eob;
        it.request_count = REQ_W'($urandom_range(0, 127));
        return it;
    endfunction

    function automatic t_in_item read_item(logic [REQ_W-1:0] cnt);
        t_in_item it;
        it.action        = ACT_READ;
        it.in_sample_i   = rand_sample();
        it.in_sample_q   = rand_sample();
        it.block_time    = {$urandom, $urandom};
        it.end_of_block  = 1'($urandom_range(0, 1));
        it.request_count = cnt;
        return it;
    endfunction

    function automatic t_result final_result(logic [STAT_W-1:0] st, logic [SAMPLE_W-1:0] si,
                                             logic [SAMPLE_W-1:0] sq, logic [TIME_W-1:0] ts,
                                             logic [LEN_W-1:0] cnt);
        t_result r;
        r.status       = st;
        r.out_sample_i = si;
        r.out_sample_q = sq;
        r.chunk_time   = ts;
        r.sample_count = cnt;
        r.last_result  = 1'b1;
        return r;
    endfunction

    function automatic void add_row(t_in_item it, bit typed, t_result want);
        t_plan_row row;
        row.item  = it;
        row.typed = typed;
        row.want  = want;
        directed_plan.push_back(row);
    endfunction

    // Advance the ring model by one transaction and queue the results it causes.
    function automatic void predict_ring_output(t_in_item it);
        int unsigned       lim;
        int unsigned       req;
        int unsigned       n;
        logic [TIME_W-1:0] t;
        t_result           r;
        r = '0;
        if (it.action == ACT_PUSH) begin
            lim = (length_limit == 0) ? 1 :
                  (length_limit > BLOCK_DEPTH) ? BLOCK_DEPTH : length_limit;
            // first sample decides: latch the stamp or drop the whole block
            if (fill_cnt == 0 && !dropping) begin
                if (next_blk(wr_blk) == rd_blk) begin
                    dropping = 1'b1;
                end else begin
                    blk_stamp[wr_blk] = it.block_time;
                end
            end
            if (!dropping && fill_cnt < lim) begin
                ring_mem[wr_blk*BLOCK_DEPTH + fill_cnt] = {it.in_sample_i, it.in_sample_q};
                fill_cnt++;
            end
            if (it.end_of_block) begin
                r.last_result = 1'b1;
                if (dropping) begin
                    r.status = STAT_FULL;
                end else begin
                    blk_len[wr_blk] = fill_cnt;
                    r.status        = STAT_COMMIT;
                    r.chunk_time    = blk_stamp[wr_blk];
                    r.sample_count  = LEN_W'(fill_cnt);
                    wr_blk          = next_blk(wr_blk);
                end
                awaited_results.push_back(r);
                fill_cnt = 0;
                dropping = 1'b0;
            end
        end else if (wr_blk == rd_blk) begin
            r.status      = STAT_EMPTY;
            r.last_result = 1'b1;
            awaited_results.push_back(r);
        end else begin
            req = (it.request_count > READ_CAP) ? READ_CAP : it.request_count;
            n   = (blk_len[rd_blk] <= req) ? blk_len[rd_blk] : req;
            t   = blk_stamp[rd_blk];
            r.status       = STAT_DATA;
            r.chunk_time   = t;
            r.sample_count = LEN_W'(n);
            if (n == 0) begin
                r.last_result = 1'b1;
                awaited_results.push_back(r);
            end
            for (int k = 0; k < n; k++) begin
                {r.out_sample_i, r.out_sample_q} = ring_mem[rd_blk*BLOCK_DEPTH + rd_pos + k];
                r.last_result = (k + 1 == n);
                awaited_results.push_back(r);
            end
            blk_stamp[rd_blk] = t + n;
            if (blk_len[rd_blk] <= req) begin
                blk_len[rd_blk] = 0;
                rd_pos          = 0;
                rd_blk          = next_blk(rd_blk);
            end else begin
                blk_len[rd_blk] -= n;
                rd_pos          += n;
            end
        end
    endfunction

    // Drive one transaction; a typed row replaces the modeled result with its own.
    task automatic send_item(t_in_item it, int idle_pct, bit typed = 1'b0,
                             t_result want = '0);
        if ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy !== 1'b0);
        predict_ring_output(it);
        if (typed)
            awaited_results[awaited_results.size()-1] = want;
    endtask

    task automatic wait_for_drain();
        start <= 1'b0;
        do @(posedge i_clk); while (awaited_results.size() != 0);
    endtask

    task automatic write_length_limit(logic [LEN_W-1:0] value);
        wait_for_drain();
        repeat (4) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        length_limit = value;
        i_cfg_we    <= 1'b0;
    endtask

    // Close any open block, then read until the ring is empty.
    task automatic settle_ring();
        if (fill_cnt != 0 || dropping)
            send_item(push_item(rand_sample(), rand_sample(), {$urandom, $urandom}, 1'b1), 0);
        while (rd_blk != wr_blk)
            send_item(read_item(7'd64), 0);
    endtask

    task automatic run_phase(int n_items, int push_pct, int idle_pct);
        int                sent;
        int                len;
        int                pick;
        logic [TIME_W-1:0] ts;
        logic [REQ_W-1:0]  cnt;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < push_pct) begin
                case ($urandom_range(0, 19))
                    0:             len = $urandom_range(21, 70);
                    1, 2, 3, 4, 5: len = $urandom_range(5, 20);
                    default:       len = $urandom_range(1, 4);
                endcase
                // a block cut at the end of the phase is closed early on its last sample
                if (len > n_items - sent)
                    len = n_items - sent;
                // near the top of the range so chunk stamps wrap
                ts = ($urandom_range(0, 9) == 0) ?
                     64'hFFFF_FFFF_FFFF_FFC0 + 64'($urandom_range(0, 63)) :
                     {$urandom, $urandom};
                for (int j = 0; j < len; j++) begin
                    send_item(push_item(rand_sample(), rand_sample(),
                                        (j == 0) ? ts : {$urandom, $urandom}, j == len - 1),
                              idle_pct);
                    sent++;
                end
            end else if (pick < 95) begin
                case ($urandom_range(0, 9))
                    0:       cnt = '0;
                    1:       cnt = REQ_W'($urandom_range(READ_CAP + 1, 127));
                    2, 3, 4: cnt = REQ_W'($urandom_range(1, READ_CAP));
                    default: cnt = REQ_W'($urandom_range(1, 8));
                endcase
                send_item(read_item(cnt), idle_pct);
                sent++;
            end else begin
                // stray sample: extends the open block, sometimes closes it
                send_item(push_item(rand_sample(), rand_sample(),
                                    {$urandom, $urandom}, 1'($urandom_range(0, 1))), idle_pct);
                sent++;
            end
        end
    endtask

    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && o_result_valid) begin
            if (awaited_results.size() == 0) begin
                if (error_count < REPORT_LIMIT)
                    $display("unexpected result: status %0d i %h q %h t %h n %0d last %0b",
                             o_result.status, o_result.out_sample_i, o_result.out_sample_q,
                             o_result.chunk_time, o_result.sample_count, o_result.last_result);
                error_count++;
            end else begin
                want = awaited_results.pop_front();
                if (o_result.status !== want.status ||
                    o_result.out_sample_i !== want.out_sample_i ||
                    o_result.out_sample_q !== want.out_sample_q ||
                    o_result.chunk_time !== want.chunk_time ||
                    o_result.sample_count !== want.sample_count ||
                    o_result.last_result !== want.last_result) begin
                    if (error_count < REPORT_LIMIT) begin
                        $display("mismatch exp: status %0d i %h q %h t %h n %0d last %0b",
                                 want.status, want.out_sample_i, want.out_sample_q,
                                 want.chunk_time, want.sample_count, want.last_result);
                        $display("         got: status %0d i %h q %h t %h n %0d last %0b",
                                 o_result.status, o_result.out_sample_i,
                                 o_result.out_sample_q, o_result.chunk_time,
                                 o_result.sample_count, o_result.last_result);
                    end
                    error_count++;
                end
            end
        end
    end

    // Count cycles in which nothing moves; a hang ends the run.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && busy === 1'b0) || o_result_valid || i_cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        // empty ring, then extremes of samples, stamps and request counts
        add_row(read_item(7'd5), 1'b1, final_result(STAT_EMPTY, '0, '0, '0, '0));
        add_row(push_item(16'hFFFF, 16'h0000, '1, 1'b1), 1'b1,
                final_result(STAT_COMMIT, '0, '0, '1, 9'd1));
        add_row(read_item(7'd0), 1'b1, final_result(STAT_DATA, '0, '0, '1, 9'd0));
        add_row(read_item(7'd127), 1'b1,
                final_result(STAT_DATA, 16'hFFFF, 16'h0000, '1, 9'd1));
        add_row(push_item(16'h0000, 16'hFFFF, '0, 1'b0), 1'b0, '0);
        add_row(push_item(16'h1234, 16'h5678, {$urandom, $urandom}, 1'b0), 1'b0, '0);
        add_row(push_item(16'h8000, 16'h0001, {$urandom, $urandom}, 1'b1), 1'b1,
                final_result(STAT_COMMIT, '0, '0, '0, 9'd3));
        // partial read, then the rest with an advanced stamp
        add_row(read_item(7'd2), 1'b0, '0);
        add_row(read_item(7'd1), 1'b0, '0);
        // fill the ring: seven blocks leave one slot unused
        for (int b = 0; b < RING_BLOCKS - 1; b++)
            add_row(push_item(16'(b), ~16'(b), 64'(b) << 40, 1'b1), 1'b1,
                    final_result(STAT_COMMIT, '0, '0, 64'(b) << 40, 9'd1));
        // block starts on a full ring: stays dropped though a read frees a slot
        add_row(push_item(16'hAAAA, 16'h5555, {$urandom, $urandom}, 1'b0), 1'b0, '0);
        add_row(read_item(7'd64), 1'b0, '0);
        add_row(push_item(16'h5555, 16'hAAAA, {$urandom, $urandom}, 1'b1), 1'b1,
                final_result(STAT_FULL, '0, '0, '0, '0));
        add_row(push_item(16'hC3C3, 16'h3C3C, 64'h0123_4567_89AB_CDEF, 1'b1), 1'b1,
                final_result(STAT_COMMIT, '0, '0, 64'h0123_4567_89AB_CDEF, 9'd1));

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_plan[r])
            send_item(directed_plan[r].item, 25, directed_plan[r].typed, directed_plan[r].want);

        run_phase(6, 55, 25);
        write_length_limit(9'd1);
        run_phase(6, 55, 25);
        write_length_limit(9'd0);
        run_phase(6, 30, 25);
        write_length_limit(9'd3);
        run_phase(8, 75, 25);

        // limit above capacity: a long block clamps at capacity
        write_length_limit(9'd511);
        settle_ring();
        for (int j = 0; j < BLOCK_DEPTH + 1; j++)
            send_item(push_item(rand_sample(), rand_sample(),
                                {$urandom, $urandom}, j == BLOCK_DEPTH), 0);
        settle_ring();

        // lower the limit under an open block: samples already held stay
        for (int j = 0; j < 5; j++)
            send_item(push_item(rand_sample(), rand_sample(),
                                (j == 0) ? 64'h0000_0000_DEAD_BEEF : {$urandom, $urandom},
                                1'b0), 0);
        write_length_limit(9'd2);
        send_item(push_item(rand_sample(), rand_sample(),
                            {$urandom, $urandom}, 1'b1), 0, 1'b1,
                  final_result(STAT_COMMIT, '0, '0, 64'h0000_0000_DEAD_BEEF, 9'd5));

        write_length_limit(LEN_W'($urandom_range(1, 300)));
        run_phase(4, 55, 25);
        wait_for_drain();
        run_phase(4, 55, 25);

        write_length_limit(LIMIT_RESET);
        run_phase(10, 55, 0);

        wait_for_drain();
        repeat (8) @(posedge i_clk);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/tsr_pkg.sv
rtl/core/tsr_ram.sv
rtl/core/tsr_ctrl.sv
rtl/core/tsr_datapath.sv
rtl/core/timestamped_sample_ring.sv
rtl/core/tsr_checker.sv
verif/timestamped_sample_ring_tb.sv
